// ===== sv/tsft_pkg.sv =====
package tsft_pkg;

  localparam int unsigned SESSION_SLOTS_DEFAULT = 1024;

  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned VER_W     = 16;
  localparam int unsigned PK_W      = 4;
  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned FLAGS_W   = 10;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TIMEOUT_W-1:0] ESTABLISHED_TIMEOUT_RST = 16'd7200;
  localparam logic [TIMEOUT_W-1:0] SECURITY_TIMEOUT_RST    = 16'd30;
  localparam logic [TIMEOUT_W-1:0] EMBRYONIC_TIMEOUT_RST   = 16'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ESTABLISHED_TIMEOUT = 2'd0,
    CFG_SECURITY_TIMEOUT    = 2'd1,
    CFG_EMBRYONIC_TIMEOUT   = 2'd2
  } tsft_cfg_e;

  // tcp flag bit positions
  localparam int unsigned PK_FIN = 0;
  localparam int unsigned PK_SYN = 1;
  localparam int unsigned PK_RST = 2;
  localparam int unsigned PK_ACK = 3;

  localparam logic [PK_W-1:0] PK_PURE_SYN = 4'b0010;

  // session flag word bit positions
  localparam int unsigned FB_WAIT_RESP_SYN     = 0;
  localparam int unsigned FB_WAIT_INIT_ACK_SYN = 1;
  localparam int unsigned FB_WAIT_RESP_ACK_SYN = 2;
  localparam int unsigned FB_SEEN_FIN_INIT     = 3;
  localparam int unsigned FB_SEEN_FIN_RESP     = 4;
  localparam int unsigned FB_ACK_FIN_INIT      = 5;
  localparam int unsigned FB_ACK_FIN_RESP      = 6;
  localparam int unsigned FB_ESTABLISHED       = 7;
  localparam int unsigned FB_REMOVING          = 8;
  localparam int unsigned FB_BLOCKED           = 9;

  localparam logic [FLAGS_W-1:0] FL_WAIT_RESP_SYN     = 10'h001;
  localparam logic [FLAGS_W-1:0] FL_WAIT_INIT_ACK_SYN = 10'h002;
  localparam logic [FLAGS_W-1:0] FL_WAIT_RESP_ACK_SYN = 10'h004;
  localparam logic [FLAGS_W-1:0] FL_ESTABLISHED       = 10'h080;
  localparam logic [FLAGS_W-1:0] FL_REMOVING          = 10'h100;
  localparam logic [FLAGS_W-1:0] FL_BLOCKED           = 10'h200;

  typedef struct packed {
    logic             direction;
    logic [VER_W-1:0] sess_gen;
    logic [PK_W-1:0]  tcp_flag_bits;
    logic [SEQ_W-1:0] tcp_seq;
    logic [SEQ_W-1:0] tcp_ack;
    logic             later_fragment;
  } tsft_item_t;

  typedef struct packed {
    logic [FLAGS_W-1:0] flags;
    logic [SEQ_W-1:0]   fwd_fin;
    logic [SEQ_W-1:0]   rev_fin;
    logic [VER_W-1:0]   version;
  } tsft_row_t;

endpackage

// ===== sv/tsft_ram.sv =====
module tsft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tsft_front.sv =====
module tsft_front
  import tsft_pkg::*;
#(
  parameter int unsigned SessionSlots = SESSION_SLOTS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [SLOT_W-1:0]               session_slot_i,
  input  logic                            direction_i,
  input  logic [VER_W-1:0]                sess_gen_i,
  input  logic [PK_W-1:0]                 tcp_flag_bits_i,
  input  logic [SEQ_W-1:0]                tcp_seq_i,
  input  logic [SEQ_W-1:0]                tcp_ack_i,
  input  logic                            later_fragment_i,
  input  logic                            clear_busy_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output logic [$clog2(SessionSlots)-1:0] push_idx_o,
  output tsft_item_t                      push_item_o
);

  localparam int unsigned AW        = $clog2(SessionSlots);
  localparam int unsigned SlotRange = 2 ** SLOT_W;

  logic              s1_valid_q;
  logic [SLOT_W-1:0] s1_slot_q;
  tsft_item_t        s1_item_q;
  logic              accept;

  assign in_stall_o = clear_busy_i || (s1_valid_q && !push_ready_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (push_ready_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_slot_q                <= session_slot_i;
      s1_item_q.direction      <= direction_i;
      s1_item_q.sess_gen       <= sess_gen_i;
      s1_item_q.tcp_flag_bits  <= tcp_flag_bits_i;
      s1_item_q.tcp_seq        <= tcp_seq_i;
      s1_item_q.tcp_ack        <= tcp_ack_i;
      s1_item_q.later_fragment <= later_fragment_i;
    end
  end

  // slot index modulo the table depth
  if (SessionSlots >= SlotRange) begin : g_direct
    assign push_idx_o = AW'(s1_slot_q);
  end else begin : g_mod
    localparam int unsigned RecipShift = 2 * SLOT_W;
    localparam int unsigned RecipW     = RecipShift + 1;
    localparam int unsigned ProdW      = SLOT_W + RecipW;
    localparam int unsigned Recip      = (2 ** RecipShift + SessionSlots - 1) / SessionSlots;

    logic [ProdW-1:0]     quot_prod;
    logic [SLOT_W-1:0]    quot_q;
    logic [RecipShift-1:0] back_prod;
    logic [SLOT_W-1:0]    rem;

    assign quot_prod = ProdW'(session_slot_i) * ProdW'(Recip);

    always_ff @(posedge clk_i) begin
      if (accept) begin
        quot_q <= quot_prod[RecipShift +: SLOT_W];
      end
    end

    assign back_prod  = RecipShift'(quot_q) * RecipShift'(SessionSlots);
    assign rem        = s1_slot_q - back_prod[SLOT_W-1:0];
    assign push_idx_o = rem[AW-1:0];
  end

  assign push_valid_o = s1_valid_q;
  assign push_item_o  = s1_item_q;

endmodule

// ===== sv/tsft_queue.sv =====
module tsft_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned Depth = 2;

  logic [Width-1:0] data_q [Depth];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = count_q != 2'(Depth);
  assign pop_valid_o  = count_q != 2'd0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = data_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/tsft_back.sv =====
module tsft_back
  import tsft_pkg::*;
#(
  parameter int unsigned SessionSlots = SESSION_SLOTS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [CFG_IDX_W-1:0]            cfg_idx_i,
  input  logic [TIMEOUT_W-1:0]            cfg_wdata_i,
  output logic                            clear_busy_o,
  input  logic                            pop_valid_i,
  output logic                            pop_ready_o,
  input  logic [$clog2(SessionSlots)-1:0] pop_idx_i,
  input  tsft_item_t                      pop_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [FLAGS_W-1:0]              old_flags_o,
  output logic [FLAGS_W-1:0]              new_flags_o,
  output logic                            evict_session_o,
  output logic                            force_drop_o,
  output logic                            became_established_o,
  output logic [TIMEOUT_W-1:0]            timeout_value_o,
  output logic                            passed_untouched_o
);

  localparam int unsigned AW = $clog2(SessionSlots);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                state_q;
  logic [AW-1:0]         clr_addr_q;
  logic [AW-1:0]         idx_q;
  tsft_item_t            item_q;
  logic [TIMEOUT_W-1:0]  established_timeout_q;
  logic [TIMEOUT_W-1:0]  security_timeout_q;
  logic [TIMEOUT_W-1:0]  embryonic_timeout_q;

  logic                  out_valid_q;
  logic [FLAGS_W-1:0]    old_flags_q;
  logic [FLAGS_W-1:0]    new_flags_q;
  logic                  evict_session_q;
  logic                  force_drop_q;
  logic                  became_established_q;
  logic [TIMEOUT_W-1:0]  timeout_value_q;
  logic                  passed_untouched_q;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  tsft_row_t             ram_wdata;
  logic                  ram_re;
  tsft_row_t             row;
  logic                  out_free;
  logic                  exec_fire;

  logic [FLAGS_W-1:0]    sf;
  logic [FLAGS_W-1:0]    nsf;
  logic [SEQ_W-1:0]      ffin;
  logic [SEQ_W-1:0]      rfin;
  logic [SEQ_W-1:0]      ffin_n;
  logic [SEQ_W-1:0]      rfin_n;
  logic                  rm;
  logic                  drop;
  logic                  est;
  logic [TIMEOUT_W-1:0]  tmo;

  tsft_ram #(
    .Width ($bits(tsft_row_t)),
    .Depth (SessionSlots)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pop_idx_i),
    .rdata_o (row)
  );

  assign clear_busy_o = state_q == S_CLEAR;
  assign pop_ready_o  = state_q == S_IDLE;
  assign ram_re       = pop_valid_i && pop_ready_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign exec_fire    = state_q == S_EXEC && out_free;

  // session update
  always_comb begin
    logic ver_chg;
    logic pure_syn;
    logic stop;
    logic syn;
    logic ack;
    logic fin;
    logic rst;

    ver_chg  = row.version != item_q.sess_gen;
    pure_syn = item_q.tcp_flag_bits == PK_PURE_SYN;
    syn      = item_q.tcp_flag_bits[PK_SYN];
    ack      = item_q.tcp_flag_bits[PK_ACK];
    fin      = item_q.tcp_flag_bits[PK_FIN];
    rst      = item_q.tcp_flag_bits[PK_RST];

    sf     = ver_chg ? (pure_syn ? '0 : FL_BLOCKED) : row.flags;
    ffin   = ver_chg ? '0 : row.fwd_fin;
    rfin   = ver_chg ? '0 : row.rev_fin;
    drop   = ver_chg && !pure_syn;
    nsf    = sf;
    ffin_n = ffin;
    rfin_n = rfin;
    rm     = 1'b0;
    est    = 1'b0;
    stop   = 1'b0;

    if (sf[FB_BLOCKED]) begin
      stop = 1'b1;
    end else if (!item_q.direction) begin
      if (syn && sf != '0) begin
        rm   = 1'b1;
        stop = 1'b1;
      end else begin
        if (syn) begin
          nsf = FL_WAIT_RESP_SYN | FL_WAIT_RESP_ACK_SYN;
        end
        if (ack) begin
          if (sf[FB_WAIT_INIT_ACK_SYN]) begin
            nsf[FB_WAIT_INIT_ACK_SYN] = 1'b0;
          end
          if (sf[FB_SEEN_FIN_RESP] && item_q.tcp_ack == rfin) begin
            nsf[FB_ACK_FIN_INIT] = 1'b1;
          end
        end
        if (fin) begin
          nsf[FB_ESTABLISHED]  = 1'b0;
          ffin_n               = item_q.tcp_seq + 32'd1;
          nsf[FB_SEEN_FIN_INIT] = 1'b1;
        end
        if (rst) begin
          rm   = 1'b1;
          stop = 1'b1;
        end
      end
    end else begin
      if (syn && sf[FB_WAIT_RESP_SYN]) begin
        nsf = nsf ^ (FL_WAIT_RESP_SYN | FL_WAIT_INIT_ACK_SYN);
      end
      if (ack) begin
        if (sf[FB_WAIT_RESP_ACK_SYN]) begin
          nsf[FB_WAIT_RESP_ACK_SYN] = 1'b0;
        end
        if (sf[FB_SEEN_FIN_INIT] && item_q.tcp_ack == ffin) begin
          nsf[FB_ACK_FIN_RESP] = 1'b1;
        end
      end
      if (fin) begin
        nsf[FB_ESTABLISHED]   = 1'b0;
        rfin_n                = item_q.tcp_seq + 32'd1;
        nsf[FB_SEEN_FIN_RESP] = 1'b1;
      end
      if (rst) begin
        nsf  = FL_REMOVING;
        rm   = 1'b1;
        stop = 1'b1;
      end
    end

    if (!stop) begin
      if (nsf == '0) begin
        nsf = FL_ESTABLISHED;
        est = 1'b1;
      end
      if (nsf[FB_ACK_FIN_INIT] && nsf[FB_ACK_FIN_RESP]) begin
        nsf = FL_REMOVING;
        rm  = 1'b1;
      end
    end

    if (rm) begin
      tmo = '0;
    end else if (nsf[FB_ESTABLISHED]) begin
      tmo = established_timeout_q;
    end else if (nsf[FB_BLOCKED]) begin
      tmo = security_timeout_q;
    end else begin
      tmo = embryonic_timeout_q;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '{flags: nsf, fwd_fin: ffin_n, rev_fin: rfin_n,
                  version: item_q.sess_gen};
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (exec_fire && !item_q.later_fragment) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == AW'(SessionSlots - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (ram_re) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      idx_q  <= pop_idx_i;
      item_q <= pop_item_i;
    end
    if (exec_fire) begin
      if (item_q.later_fragment) begin
        old_flags_q          <= row.flags;
        new_flags_q          <= row.flags;
        evict_session_q      <= 1'b0;
        force_drop_q         <= 1'b0;
        became_established_q <= 1'b0;
        timeout_value_q      <= '0;
        passed_untouched_q   <= 1'b1;
      end else begin
        old_flags_q          <= sf;
        new_flags_q          <= nsf;
        evict_session_q      <= rm;
        force_drop_q         <= drop;
        became_established_q <= est;
        timeout_value_q      <= tmo;
        passed_untouched_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      established_timeout_q <= ESTABLISHED_TIMEOUT_RST;
      security_timeout_q    <= SECURITY_TIMEOUT_RST;
      embryonic_timeout_q   <= EMBRYONIC_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ESTABLISHED_TIMEOUT: established_timeout_q <= cfg_wdata_i;
        CFG_SECURITY_TIMEOUT:    security_timeout_q    <= cfg_wdata_i;
        CFG_EMBRYONIC_TIMEOUT:   embryonic_timeout_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o          = out_valid_q;
  assign old_flags_o          = old_flags_q;
  assign new_flags_o          = new_flags_q;
  assign evict_session_o      = evict_session_q;
  assign force_drop_o         = force_drop_q;
  assign became_established_o = became_established_q;
  assign timeout_value_o      = timeout_value_q;
  assign passed_untouched_o   = passed_untouched_q;

endmodule

// ===== sv/tcp_session_flag_tracker_unit.sv =====
// channel  | handshake                 | words
// packet   | in_valid_i / in_stall_o   | session_slot_i .. later_fragment_i
// result   | out_valid_o / out_stall_i | old_flags_o .. passed_untouched_o
// config   | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// the update stage takes one packet at a time: session table read, then update and write back
// the front stage and a two-word queue take packets while the update stage is busy
// after reset a clearing pass zeroes every table slot, in_stall_o held high
// a stalled result holds the update stage; config writes take effect the next cycle
module tcp_session_flag_tracker_unit
  import tsft_pkg::*;
#(
  parameter int unsigned SessionSlots = SESSION_SLOTS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TIMEOUT_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SLOT_W-1:0]    session_slot_i,
  input  logic                 direction_i,
  input  logic [VER_W-1:0]     sess_gen_i,
  input  logic [PK_W-1:0]      tcp_flag_bits_i,
  input  logic [SEQ_W-1:0]     tcp_seq_i,
  input  logic [SEQ_W-1:0]     tcp_ack_i,
  input  logic                 later_fragment_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [FLAGS_W-1:0]   old_flags_o,
  output logic [FLAGS_W-1:0]   new_flags_o,
  output logic                 evict_session_o,
  output logic                 force_drop_o,
  output logic                 became_established_o,
  output logic [TIMEOUT_W-1:0] timeout_value_o,
  output logic                 passed_untouched_o
);

  localparam int unsigned AW = $clog2(SessionSlots);
  localparam int unsigned QW = AW + $bits(tsft_item_t);

  logic          clear_busy;
  logic          push_valid;
  logic          push_ready;
  logic [AW-1:0] push_idx;
  tsft_item_t    push_item;
  logic          pop_valid;
  logic          pop_ready;
  logic [QW-1:0] pop_data;
  logic [AW-1:0] pop_idx;
  tsft_item_t    pop_item;

  tsft_front #(
    .SessionSlots (SessionSlots)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .session_slot_i   (session_slot_i),
    .direction_i      (direction_i),
    .sess_gen_i       (sess_gen_i),
    .tcp_flag_bits_i  (tcp_flag_bits_i),
    .tcp_seq_i        (tcp_seq_i),
    .tcp_ack_i        (tcp_ack_i),
    .later_fragment_i (later_fragment_i),
    .clear_busy_i     (clear_busy),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_idx_o       (push_idx),
    .push_item_o      (push_item)
  );

  tsft_queue #(
    .Width (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_idx, push_item}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign pop_idx  = pop_data[QW-1 -: AW];
  assign pop_item = pop_data[$bits(tsft_item_t)-1:0];

  tsft_back #(
    .SessionSlots (SessionSlots)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .clear_busy_o         (clear_busy),
    .pop_valid_i          (pop_valid),
    .pop_ready_o          (pop_ready),
    .pop_idx_i            (pop_idx),
    .pop_item_i           (pop_item),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .old_flags_o          (old_flags_o),
    .new_flags_o          (new_flags_o),
    .evict_session_o      (evict_session_o),
    .force_drop_o         (force_drop_o),
    .became_established_o (became_established_o),
    .timeout_value_o      (timeout_value_o),
    .passed_untouched_o   (passed_untouched_o)
  );

endmodule
